// ===== hdl/kvpsa_pkg.sv =====
package kvpsa_pkg;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_EXTEND = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_BUDGET = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_IDLE_SLOT = 3'd3;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd4;

  localparam logic REG_TOK_PER_PAGE = 1'b0;
  localparam logic REG_TOTAL_PAGES  = 1'b1;

  localparam int DIV_STEPS = 16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  slot;
    logic        tok_zero;
    logic [15:0] need;
  } cmd_item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_EXEC,
    B_SCAN,
    B_OUT
  } back_state_t;

endpackage

// ===== hdl/kv_page_slot_allocator_top.sv =====
// Channel   Direction  Payload (low bit first)
// s_*       in         cmd[1:0], slot[9:2], tokens[25:10]
// m_*       out        status, slot_out, free_pages, used_pages, free_slots
// cfg_*     in         index 0 tokens per page, index 1 total_pages
// An allocate or extend with tokens passes through the sixteen-step page
// divider in the front; an allocate that fits the budget then scans the
// slots eight at a time for the lowest free slot. Other commands skip the
// divider. Reset is synchronous and needs no clearing pass. A two-entry
// queue separates the divider from the slot logic, and the output register
// holds a result while the next command is already being worked on.
module kv_page_slot_allocator_top #(
  parameter int NUM_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // cmd, slot, tokens, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // status, slot_out, free_pages, used_pages, free_slots
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import kvpsa_pkg::*;

  logic [12:0] tok_per_page;
  logic [15:0] total_pages;
  logic        fq_valid;
  logic        fq_ready;
  cmd_item_t   fq_item;
  logic        qb_valid;
  logic        qb_ready;
  cmd_item_t   qb_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_per_page <= 13'd16;
      total_pages  <= 16'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOK_PER_PAGE: tok_per_page <= cfg_data[12:0];
        REG_TOTAL_PAGES:  total_pages  <= cfg_data;
        default: ;
      endcase
    end
  end

  kvpsa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .tok_per_page (tok_per_page),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_item       (fq_item)
  );

  kvpsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  kvpsa_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (qb_valid),
    .q_ready     (qb_ready),
    .q_item      (qb_item),
    .total_pages (total_pages),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

// ===== hdl/kvpsa_front.sv =====
module kvpsa_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,
  input  logic [12:0]           tok_per_page,
  output logic                  q_valid,
  input  logic                  q_ready,
  output kvpsa_pkg::cmd_item_t  q_item
);
  import kvpsa_pkg::*;

  front_state_t state, state_next;
  logic [1:0]  cmd;
  logic [7:0]  slot;
  logic        tok_zero;
  logic [15:0] quo;
  logic [12:0] rem;
  logic [12:0] divisor;
  logic [3:0]  cnt;
  logic [13:0] shifted;
  logic        ge;
  logic        accept;
  logic        skip_div;

  assign accept   = s_tvalid && s_tready;
  assign shifted  = {rem, quo[15]};
  assign ge       = shifted >= {1'b0, divisor};
  assign skip_div = (s_tdata[25:10] == 16'd0) || (s_tdata[1:0] == CMD_FREE)
                    || (s_tdata[1:0] == CMD_UNUSED);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (s_tvalid) state_next = skip_div ? F_PUSH : F_DIV;
      F_DIV:  if (cnt == 4'(DIV_STEPS - 1)) state_next = F_PUSH;
      F_PUSH: if (q_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = (state == F_IDLE);
    q_valid       = (state == F_PUSH);
    q_item.cmd    = cmd;
    q_item.slot   = slot;
    q_item.tok_zero = tok_zero;
    if (tok_zero && cmd == CMD_ALLOC) begin
      q_item.need = 16'd1;
    end else begin
      q_item.need = quo + 16'(rem != 13'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= s_tdata[1:0];
      slot     <= s_tdata[9:2];
      tok_zero <= (s_tdata[25:10] == 16'd0);
      quo      <= skip_div ? 16'd0 : s_tdata[25:10];
      rem      <= 13'd0;
      cnt      <= 4'd0;
      divisor  <= (tok_per_page == 13'd0) ? 13'd1 : tok_per_page;
    end else if (state == F_DIV) begin
      rem <= ge ? 13'(shifted - {1'b0, divisor}) : shifted[12:0];
      quo <= {quo[14:0], ge};
      cnt <= cnt + 4'd1;
    end
  end

endmodule

// ===== hdl/kvpsa_queue.sv =====
module kvpsa_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  kvpsa_pkg::cmd_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kvpsa_pkg::cmd_item_t  out_item
);
  import kvpsa_pkg::*;

  cmd_item_t  entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = entries[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= in_item;
  end

endmodule

// ===== hdl/kvpsa_back.sv =====
module kvpsa_back #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  kvpsa_pkg::cmd_item_t  q_item,
  input  logic [15:0]           total_pages,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata
);
  import kvpsa_pkg::*;

  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int NCH = (NUM_SLOTS + 7) / 8;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int FCW = $clog2(NUM_SLOTS + 1);

  back_state_t state, state_next;
  cmd_item_t   cur;
  logic [15:0] held_mem [NUM_SLOTS];
  logic [15:0] held_rd;
  logic        mem_we;
  logic [SW-1:0] mem_waddr;
  logic [15:0] mem_wdata;

  logic [NUM_SLOTS-1:0] in_use;
  logic [NCH*8-1:0]     busy_pad;
  logic [15:0]          piu;
  logic [FCW-1:0]       free_cnt;
  logic [FCW+6:0]       free_ext;
  logic [CW-1:0]        chunk;
  logic [7:0]           chunk_bits;
  logic                 found;
  logic [2:0]           pos;
  logic [CW+2:0]        grant;
  logic [SW-1:0]        gidx;
  logic [SW-1:0]        cidx;
  logic                 slot_ok;
  logic                 fits;
  logic [16:0]          sum;
  logic                 last_chunk;
  logic [2:0]           status;
  logic [7:0]           slot_out;
  logic [2:0]           exec_status;
  logic [7:0]           exec_slot;
  logic                 out_load;

  genvar g;
  generate
    for (g = 0; g < NCH * 8; g++) begin : g_pad
      if (g < NUM_SLOTS) begin : g_real
        assign busy_pad[g] = in_use[g];
      end else begin : g_fill
        assign busy_pad[g] = 1'b1;
      end
    end
  endgenerate

  assign cidx       = SW'(cur.slot);
  assign slot_ok    = {1'b0, cur.slot} < 9'(NUM_SLOTS);
  assign sum        = {1'b0, piu} + {1'b0, cur.need};
  assign fits       = sum <= {1'b0, total_pages};
  assign chunk_bits = busy_pad[chunk*8 +: 8];
  assign last_chunk = (chunk == CW'(NCH - 1));
  assign grant      = {chunk, pos};
  assign gidx       = SW'(grant);
  assign out_load   = (state == B_OUT) && (!m_tvalid || m_tready);
  assign free_ext   = (FCW + 7)'(free_cnt);

  always_comb begin
    found = 1'b0;
    pos   = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!chunk_bits[i]) begin
        found = 1'b1;
        pos   = 3'(i);
      end
    end
  end

  always_comb begin
    exec_slot   = cur.slot;
    exec_status = ST_OK;
    unique case (cur.cmd)
      CMD_ALLOC: begin
        exec_slot = 8'd0;
        if (!fits) exec_status = ST_NO_BUDGET;
      end
      CMD_EXTEND: begin
        if (!slot_ok) begin
          exec_status = ST_BAD_SLOT;
        end else if (!cur.tok_zero) begin
          if (!in_use[cidx]) begin
            exec_status = ST_IDLE_SLOT;
          end else if (!fits) begin
            exec_status = ST_NO_BUDGET;
          end
        end
      end
      default: exec_status = ST_OK;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (q_valid) state_next = B_READ;
      B_READ: state_next = B_EXEC;
      B_EXEC: state_next = (cur.cmd == CMD_ALLOC && fits) ? B_SCAN : B_OUT;
      B_SCAN: if (found || last_chunk) state_next = B_OUT;
      B_OUT:  if (!m_tvalid || m_tready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == B_IDLE);
    mem_we    = 1'b0;
    mem_waddr = cidx;
    mem_wdata = held_rd + cur.need;
    if (state == B_EXEC && cur.cmd == CMD_EXTEND && slot_ok && !cur.tok_zero
        && in_use[cidx] && fits) begin
      mem_we = 1'b1;
    end else if (state == B_SCAN && found) begin
      mem_we    = 1'b1;
      mem_waddr = gidx;
      mem_wdata = cur.need;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) held_mem[mem_waddr] <= mem_wdata;
    held_rd <= held_mem[cidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      in_use   <= '0;
      piu      <= 16'd0;
      free_cnt <= FCW'(NUM_SLOTS);
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_EXEC && cur.cmd == CMD_EXTEND && slot_ok && !cur.tok_zero
          && in_use[cidx] && fits) begin
        piu <= sum[15:0];
      end
      if (state == B_EXEC && cur.cmd == CMD_FREE && slot_ok && in_use[cidx]) begin
        piu          <= (piu >= held_rd) ? piu - held_rd : 16'd0;
        in_use[cidx] <= 1'b0;
        free_cnt     <= free_cnt + FCW'(1);
      end
      if (state == B_SCAN && found) begin
        piu          <= sum[15:0];
        in_use[gidx] <= 1'b1;
        free_cnt     <= free_cnt - FCW'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      cur <= q_item;
    end
    if (state == B_READ) begin
      chunk <= '0;
    end else if (state == B_SCAN) begin
      chunk <= chunk + CW'(1);
    end
    if (state == B_EXEC) begin
      slot_out <= exec_slot;
      status   <= exec_status;
    end
    if (state == B_SCAN) begin
      if (found) begin
        slot_out <= 8'(grant);
      end else if (last_chunk) begin
        status <= ST_NO_SLOT;
      end
    end
    if (out_load) begin
      m_tdata <= {6'd0, free_ext[6:0], piu,
                  (total_pages > piu) ? total_pages - piu : 16'd0,
                  slot_out, status};
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import kvpsa_pkg::*;

  localparam int SLOTS = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 560;

  typedef struct packed {
    logic [6:0]  free_slots;
    logic [15:0] used_pages;
    logic [15:0] free_pages;
    logic [7:0]  slot_out;
    logic [2:0]  status;
  } alloc_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  slot;
    logic [15:0] tokens;
    bit          typed;
    logic [2:0]  status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  kv_page_slot_allocator_top #(.NUM_SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [12:0] pg_size;
  logic [15:0] pg_budget;
  bit          slot_busy [SLOTS];
  logic [15:0] slot_pages [SLOTS];
  logic [15:0] pages_used;

  alloc_result_t expected_results [$];
  bit            expected_typed [$];
  logic [2:0]    expected_status [$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            ready_hold = 0;
  bit            calm = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic logic [16:0] page_count(input logic [15:0] tok);
    logic [16:0] ps;
    ps = (pg_size == 0) ? 17'd1 : {4'd0, pg_size};
    return (17'(tok) + ps - 17'd1) / ps;
  endfunction

  function automatic alloc_result_t predict_alloc(input logic [1:0] cmd, input logic [7:0] slot,
                                                  input logic [15:0] tok);
    alloc_result_t r;
    logic [16:0] need;
    int nfree;
    r.status = ST_OK;
    r.slot_out = slot;
    if (cmd == CMD_ALLOC) begin
      need = (tok == 0) ? 17'd1 : page_count(tok);
      r.slot_out = '0;
      if (17'(pages_used) + need > 17'(pg_budget)) begin
        r.status = ST_NO_BUDGET;
      end else begin
        r.status = ST_NO_SLOT;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_busy[i] && r.status == ST_NO_SLOT) begin
            slot_busy[i] = 1'b1;
            slot_pages[i] = need[15:0];
            pages_used = pages_used + need[15:0];
            r.slot_out = 8'(i);
            r.status = ST_OK;
          end
        end
      end
    end else if (cmd == CMD_EXTEND) begin
      if (slot >= SLOTS) begin
        r.status = ST_BAD_SLOT;
      end else if (tok != 0) begin
        need = page_count(tok);
        if (!slot_busy[slot]) begin
          r.status = ST_IDLE_SLOT;
        end else if (17'(pages_used) + need > 17'(pg_budget)) begin
          r.status = ST_NO_BUDGET;
        end else begin
          slot_pages[slot] = slot_pages[slot] + need[15:0];
          pages_used = pages_used + need[15:0];
        end
      end
    end else if (cmd == CMD_FREE) begin
      if (slot < SLOTS && slot_busy[slot]) begin
        pages_used = (pages_used >= slot_pages[slot]) ? pages_used - slot_pages[slot] : '0;
        slot_pages[slot] = '0;
        slot_busy[slot] = 1'b0;
      end
    end
    nfree = 0;
    for (int i = 0; i < SLOTS; i++) if (!slot_busy[i]) nfree++;
    r.free_pages = (pg_budget > pages_used) ? pg_budget - pages_used : '0;
    r.used_pages = pages_used;
    r.free_slots = 7'(nfree);
    return r;
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TOK_PER_PAGE) pg_size = val[12:0];
    else pg_budget = val;
    @(posedge clk);
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] slot, input logic [15:0] tok,
                          input bit typed, input logic [2:0] st);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, tok, slot, cmd};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_alloc(cmd, slot, tok));
    expected_typed.push_back(typed);
    expected_status.push_back(st);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (!calm && ready_hold > 0) begin
        m_tready <= 1'b0;
        ready_hold <= ready_hold - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        ready_hold <= int'($urandom_range(0, 2));
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = alloc_result_t'(m_tdata[49:0]);
      if (expected_results.size() == 0) begin
        report("unexpected result", 32'(got.status), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (expected_typed.pop_front()) want.status = expected_status.pop_front();
        else void'(expected_status.pop_front());
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.slot_out !== want.slot_out)
          report("slot_out", 32'(got.slot_out), 32'(want.slot_out));
        if (got.free_pages !== want.free_pages)
          report("free_pages", 32'(got.free_pages), 32'(want.free_pages));
        if (got.used_pages !== want.used_pages)
          report("used_pages", 32'(got.used_pages), 32'(want.used_pages));
        if (got.free_slots !== want.free_slots)
          report("free_slots", 32'(got.free_slots), 32'(want.free_slots));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** kv_page_slot_allocator_top: FAILED **");
      $finish;
    end
  end

  stim_row_t directed [] = '{
    '{CMD_ALLOC,  8'd0,   16'd0,     1'b1, ST_OK},
    '{CMD_ALLOC,  8'd0,   16'd1,     1'b1, ST_OK},
    '{CMD_ALLOC,  8'd255, 16'd16,    1'b1, ST_OK},
    '{CMD_ALLOC,  8'd0,   16'd17,    1'b0, ST_OK},
    '{CMD_EXTEND, 8'd0,   16'd0,     1'b1, ST_OK},
    '{CMD_EXTEND, 8'd255, 16'd5,     1'b1, ST_BAD_SLOT},
    '{CMD_EXTEND, 8'd64,  16'd0,     1'b1, ST_BAD_SLOT},
    '{CMD_EXTEND, 8'd63,  16'd5,     1'b1, ST_IDLE_SLOT},
    '{CMD_EXTEND, 8'd63,  16'd0,     1'b1, ST_OK},
    '{CMD_EXTEND, 8'd1,   16'd65535, 1'b1, ST_NO_BUDGET},
    '{CMD_EXTEND, 8'd1,   16'd100,   1'b0, ST_OK},
    '{CMD_ALLOC,  8'd0,   16'd65535, 1'b1, ST_NO_BUDGET},
    '{CMD_FREE,   8'd200, 16'd0,     1'b1, ST_OK},
    '{CMD_FREE,   8'd40,  16'd0,     1'b1, ST_OK},
    '{CMD_FREE,   8'd1,   16'hFFFF,  1'b1, ST_OK},
    '{CMD_UNUSED, 8'd170, 16'hAAAA,  1'b1, ST_OK},
    '{CMD_UNUSED, 8'd85,  16'h5555,  1'b0, ST_OK},
    '{CMD_FREE,   8'd0,   16'd0,     1'b0, ST_OK},
    '{CMD_FREE,   8'd2,   16'd0,     1'b0, ST_OK},
    '{CMD_FREE,   8'd3,   16'd0,     1'b0, ST_OK}
  };

  function automatic logic [7:0] pick_slot();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'($urandom_range(64, 255));
    return 8'($urandom_range(0, SLOTS - 1));
  endfunction

  initial begin
    logic [1:0] c;
    logic [15:0] t;
    int r;
    pg_size = 13'd16;
    pg_budget = 16'd1024;
    pages_used = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_pages[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k])
      send_cmd(directed[k].cmd, directed[k].slot, directed[k].tokens,
               directed[k].typed, directed[k].status);
    for (int i = 0; i < 66; i++) send_cmd(CMD_ALLOC, 8'd0, 16'd1, 1'b0, ST_OK);
    wait_drained();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin write_reg(REG_TOK_PER_PAGE, 16'd1); write_reg(REG_TOTAL_PAGES, 16'd65535); end
        1: begin write_reg(REG_TOK_PER_PAGE, 16'd0); write_reg(REG_TOTAL_PAGES, 16'd1); end
        2: begin write_reg(REG_TOK_PER_PAGE, 16'd4096); write_reg(REG_TOTAL_PAGES, 16'd40); end
        3: begin write_reg(REG_TOK_PER_PAGE, 16'h1FFF); write_reg(REG_TOTAL_PAGES, 16'd300); end
        4: begin
          write_reg(REG_TOK_PER_PAGE, 16'($urandom_range(1, 300)));
          write_reg(REG_TOTAL_PAGES, 16'($urandom_range(50, 3000)));
        end
        5: write_reg(REG_TOTAL_PAGES, 16'd2);
        default: begin
          calm = 1'b1;
          write_reg(REG_TOK_PER_PAGE, 16'd16);
          write_reg(REG_TOTAL_PAGES, 16'd1024);
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 7; n++) begin
        r = $urandom_range(0, 99);
        if (r < 40) c = CMD_ALLOC;
        else if (r < 70) c = CMD_EXTEND;
        else if (r < 97) c = CMD_FREE;
        else c = CMD_UNUSED;
        r = $urandom_range(0, 9);
        if (r == 0) t = '0;
        else if (r == 1) t = 16'hFFFF;
        else if (r < 5) t = 16'($urandom);
        else t = 16'($urandom_range(1, 200));
        send_cmd(c, pick_slot(), t, 1'b0, ST_OK);
        if (n == 40 && phase == 2) wait_drained();
      end
      wait_drained();
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** kv_page_slot_allocator_top: PASSED **");
    end else begin
      $display("** kv_page_slot_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== kv_page_slot_allocator_top.f =====
hdl/kvpsa_pkg.sv
hdl/kvpsa_front.sv
hdl/kvpsa_queue.sv
hdl/kvpsa_back.sv
hdl/kv_page_slot_allocator_top.sv
verif/testbench.sv
